[src/v3a_pkg.sv]
// Shared types, operation codes and helper functions for the vector arithmetic unit.
// No dependencies; every other file in src uses it.
`default_nettype none

package v3a_pkg;

  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_SUB   = 3'd1;
  localparam logic [2:0] OP_SCALE = 3'd2;
  localparam logic [2:0] OP_DOT   = 3'd3;
  localparam logic [2:0] OP_CROSS = 3'd4;
  localparam logic [2:0] OP_NORM  = 3'd5;

  localparam int SQRT_STAGES = 32;
  localparam int DIV_STAGES  = 17;

  localparam logic signed [65:0] Q_MAX_W = 66'sd2147483647;
  localparam logic signed [65:0] Q_MIN_W = -66'sd2147483648;

  typedef struct packed {
    logic        [2:0]  operation;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] scale_factor;
  } v3a_in_t;

  typedef struct packed {
    logic signed [31:0] res_x;
    logic signed [31:0] res_y;
    logic signed [31:0] res_z;
    logic signed [31:0] res_scalar;
    logic               overflow;
    logic               zero_length;
  } v3a_out_t;

  // Everything an item carries alongside the square root and divide lanes.
  typedef struct packed {
    logic [2:0]       op;
    logic [31:0]      rx;
    logic [31:0]      ry;
    logic [31:0]      rz;
    logic [31:0]      rs;
    logic             ovf;
    logic             zl;
    logic [2:0][31:0] mag;
    logic [2:0]       neg;
  } v3a_tag_t;

  // Saturate a wide signed value to 32 bits; the top bit of the result is the flag.
  function automatic logic [32:0] sat_q(input logic signed [65:0] v);
    logic [32:0] res;
    if (v > Q_MAX_W) begin
      res = {1'b1, 32'h7FFF_FFFF};
    end else if (v < Q_MIN_W) begin
      res = {1'b1, 32'h8000_0000};
    end else begin
      res = {1'b0, v[31:0]};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[src/v3a_front.sv]
// Front end: operand multiplexing, six multipliers, then combining and saturation.
// Depends on v3a_pkg.
`default_nettype none

module v3a_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             adv,
  input  wire logic             in_valid,
  input  wire v3a_pkg::v3a_in_t in_data,
  output logic                  out_valid,
  output logic [63:0]           out_sum_sq,
  output v3a_pkg::v3a_tag_t     out_tag
);

  logic signed [31:0] m_a [6];
  logic signed [31:0] m_b [6];
  logic signed [63:0] prod [6];

  logic               v1_r;
  logic [2:0]         op1_r;
  logic signed [63:0] p_r [6];
  logic signed [32:0] sx_r, sy_r, sz_r;
  logic [2:0][31:0]   mag1_r;
  logic [2:0]         neg1_r;

  logic               v2_r;
  logic [63:0]        ssq_r;
  v3a_pkg::v3a_tag_t  tag_r;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      m_a[k] = '0;
      m_b[k] = '0;
    end
    case (in_data.operation)
      v3a_pkg::OP_SCALE: begin
        m_a[0] = in_data.scale_factor; m_b[0] = in_data.a_x;
        m_a[1] = in_data.scale_factor; m_b[1] = in_data.a_y;
        m_a[2] = in_data.scale_factor; m_b[2] = in_data.a_z;
      end
      v3a_pkg::OP_DOT: begin
        m_a[0] = in_data.a_x; m_b[0] = in_data.b_x;
        m_a[1] = in_data.a_y; m_b[1] = in_data.b_y;
        m_a[2] = in_data.a_z; m_b[2] = in_data.b_z;
      end
      v3a_pkg::OP_CROSS: begin
        m_a[0] = in_data.a_y; m_b[0] = in_data.b_z;
        m_a[3] = in_data.a_z; m_b[3] = in_data.b_y;
        m_a[1] = in_data.a_z; m_b[1] = in_data.b_x;
        m_a[4] = in_data.a_x; m_b[4] = in_data.b_z;
        m_a[2] = in_data.a_x; m_b[2] = in_data.b_y;
        m_a[5] = in_data.a_y; m_b[5] = in_data.b_x;
      end
      v3a_pkg::OP_NORM: begin
        m_a[0] = in_data.a_x; m_b[0] = in_data.a_x;
        m_a[1] = in_data.a_y; m_b[1] = in_data.a_y;
        m_a[2] = in_data.a_z; m_b[2] = in_data.a_z;
      end
      default: begin
      end
    endcase
    for (int k = 0; k < 6; k++) begin
      prod[k] = m_a[k] * m_b[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op1_r <= in_data.operation;
      for (int k = 0; k < 6; k++) begin
        p_r[k] <= prod[k];
      end
      if (in_data.operation == v3a_pkg::OP_SUB) begin
        sx_r <= 33'(in_data.a_x) - 33'(in_data.b_x);
        sy_r <= 33'(in_data.a_y) - 33'(in_data.b_y);
        sz_r <= 33'(in_data.a_z) - 33'(in_data.b_z);
      end else begin
        sx_r <= 33'(in_data.a_x) + 33'(in_data.b_x);
        sy_r <= 33'(in_data.a_y) + 33'(in_data.b_y);
        sz_r <= 33'(in_data.a_z) + 33'(in_data.b_z);
      end
      neg1_r    <= {in_data.a_z[31], in_data.a_y[31], in_data.a_x[31]};
      mag1_r[0] <= in_data.a_x[31] ? 32'(-in_data.a_x) : in_data.a_x;
      mag1_r[1] <= in_data.a_y[31] ? 32'(-in_data.a_y) : in_data.a_y;
      mag1_r[2] <= in_data.a_z[31] ? 32'(-in_data.a_z) : in_data.a_z;
    end
  end

  // Second stage: full-precision sums, floor by arithmetic shift, saturation.
  logic signed [65:0] w [3];
  logic [32:0]        s [3];
  logic [32:0]        sd;
  logic [63:0]        ssq;
  v3a_pkg::v3a_tag_t  tag_nxt;

  always_comb begin
    tag_nxt     = '0;
    tag_nxt.op  = op1_r;
    tag_nxt.mag = mag1_r;
    tag_nxt.neg = neg1_r;
    ssq = 64'(p_r[0]) + 64'(p_r[1]) + 64'(p_r[2]);
    for (int k = 0; k < 3; k++) begin
      if (op1_r == v3a_pkg::OP_CROSS) begin
        w[k] = (66'(p_r[k]) - 66'(p_r[k + 3])) >>> 16;
      end else begin
        w[k] = 66'(p_r[k]) >>> 16;
      end
      s[k] = v3a_pkg::sat_q(w[k]);
    end
    sd = v3a_pkg::sat_q((66'(p_r[0]) + 66'(p_r[1]) + 66'(p_r[2])) >>> 16);
    case (op1_r)
      v3a_pkg::OP_ADD, v3a_pkg::OP_SUB: begin
        s[0] = v3a_pkg::sat_q(66'(sx_r));
        s[1] = v3a_pkg::sat_q(66'(sy_r));
        s[2] = v3a_pkg::sat_q(66'(sz_r));
        tag_nxt.rx  = s[0][31:0];
        tag_nxt.ry  = s[1][31:0];
        tag_nxt.rz  = s[2][31:0];
        tag_nxt.ovf = s[0][32] | s[1][32] | s[2][32];
      end
      v3a_pkg::OP_SCALE, v3a_pkg::OP_CROSS: begin
        tag_nxt.rx  = s[0][31:0];
        tag_nxt.ry  = s[1][31:0];
        tag_nxt.rz  = s[2][31:0];
        tag_nxt.ovf = s[0][32] | s[1][32] | s[2][32];
      end
      v3a_pkg::OP_DOT: begin
        tag_nxt.rs  = sd[31:0];
        tag_nxt.ovf = sd[32];
      end
      v3a_pkg::OP_NORM: begin
        tag_nxt.zl = (ssq == 64'd0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ssq_r <= ssq;
      tag_r <= tag_nxt;
    end
  end

  assign out_valid  = v2_r;
  assign out_sum_sq = ssq_r;
  assign out_tag    = tag_r;

endmodule

`default_nettype wire

[src/v3a_sqrt.sv]
// Pipelined integer square root, one result bit per register stage.
// Depends on v3a_pkg.
`default_nettype none

module v3a_sqrt (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              adv,
  input  wire logic              in_valid,
  input  wire logic [63:0]       in_s,
  input  wire v3a_pkg::v3a_tag_t in_tag,
  output logic                   out_valid,
  output logic [31:0]            out_root,
  output v3a_pkg::v3a_tag_t      out_tag
);

  logic              vld_r  [v3a_pkg::SQRT_STAGES];
  logic [63:0]       rem_r  [v3a_pkg::SQRT_STAGES];
  logic [63:0]       root_r [v3a_pkg::SQRT_STAGES];
  v3a_pkg::v3a_tag_t tag_r  [v3a_pkg::SQRT_STAGES];

  for (genvar k = 0; k < v3a_pkg::SQRT_STAGES; k++) begin : g_st
    localparam int SH = 62 - 2 * k;
    logic              vld_i;
    logic [63:0]       rem_i, root_i, rem_o, root_o, bitv;
    logic [64:0]       trial;
    v3a_pkg::v3a_tag_t tag_i;

    if (k == 0) begin : g_first
      assign vld_i  = in_valid;
      assign rem_i  = in_s;
      assign root_i = '0;
      assign tag_i  = in_tag;
    end else begin : g_next
      assign vld_i  = vld_r[k - 1];
      assign rem_i  = rem_r[k - 1];
      assign root_i = root_r[k - 1];
      assign tag_i  = tag_r[k - 1];
    end

    assign bitv  = 64'd1 << SH;
    assign trial = 65'(root_i) + 65'(bitv);

    always_comb begin
      if ({1'b0, rem_i} >= trial) begin
        rem_o  = rem_i - trial[63:0];
        root_o = (root_i >> 1) + bitv;
      end else begin
        rem_o  = rem_i;
        root_o = root_i >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k]  <= rem_o;
        root_r[k] <= root_o;
        tag_r[k]  <= tag_i;
      end
    end
  end

  assign out_valid = vld_r[v3a_pkg::SQRT_STAGES - 1];
  assign out_root  = root_r[v3a_pkg::SQRT_STAGES - 1][31:0];
  assign out_tag   = tag_r[v3a_pkg::SQRT_STAGES - 1];

endmodule

`default_nettype wire

[src/v3a_div.sv]
// Three-lane pipelined restoring divider, magnitude * 65536 / root, one quotient bit a stage.
// Depends on v3a_pkg.
`default_nettype none

module v3a_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              adv,
  input  wire logic              in_valid,
  input  wire logic [31:0]       in_root,
  input  wire v3a_pkg::v3a_tag_t in_tag,
  output logic                   out_valid,
  output logic [2:0][16:0]       out_q,
  output v3a_pkg::v3a_tag_t      out_tag
);

  logic              vld_r  [v3a_pkg::DIV_STAGES];
  logic [31:0]       root_r [v3a_pkg::DIV_STAGES];
  logic [2:0][48:0]  rem_r  [v3a_pkg::DIV_STAGES];
  logic [2:0][16:0]  q_r    [v3a_pkg::DIV_STAGES];
  v3a_pkg::v3a_tag_t tag_r  [v3a_pkg::DIV_STAGES];

  for (genvar k = 0; k < v3a_pkg::DIV_STAGES; k++) begin : g_st
    localparam int SH = v3a_pkg::DIV_STAGES - 1 - k;
    logic              vld_i;
    logic [31:0]       root_i;
    logic [2:0][48:0]  rem_i, rem_o;
    logic [2:0][16:0]  q_i, q_o;
    logic [48:0]       trial;
    v3a_pkg::v3a_tag_t tag_i;

    if (k == 0) begin : g_first
      assign vld_i  = in_valid;
      assign root_i = in_root;
      assign tag_i  = in_tag;
      for (genvar l = 0; l < 3; l++) begin : g_init
        assign rem_i[l] = {1'b0, in_tag.mag[l], 16'd0};
        assign q_i[l]   = '0;
      end
    end else begin : g_next
      assign vld_i  = vld_r[k - 1];
      assign root_i = root_r[k - 1];
      assign tag_i  = tag_r[k - 1];
      assign rem_i  = rem_r[k - 1];
      assign q_i    = q_r[k - 1];
    end

    assign trial = 49'(root_i) << SH;

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        if (rem_i[l] >= trial) begin
          rem_o[l] = rem_i[l] - trial;
          q_o[l]   = q_i[l] | (17'd1 << SH);
        end else begin
          rem_o[l] = rem_i[l];
          q_o[l]   = q_i[l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        root_r[k] <= root_i;
        rem_r[k]  <= rem_o;
        q_r[k]    <= q_o;
        tag_r[k]  <= tag_i;
      end
    end
  end

  assign out_valid = vld_r[v3a_pkg::DIV_STAGES - 1];
  assign out_q     = q_r[v3a_pkg::DIV_STAGES - 1];
  assign out_tag   = tag_r[v3a_pkg::DIV_STAGES - 1];

endmodule

`default_nettype wire

[src/vec3_arithmetic_unit.sv]
// Top level of the three-component vector arithmetic unit (signed Q16.16).
// Depends on v3a_pkg, v3a_front, v3a_sqrt and v3a_div.
`default_nettype none

// The unit takes one item per clock cycle while the output side does not stall and
// returns exactly one result item for each, in order, after the front end's multiply
// and combine registers, 32 stages of square root, 17 stages of divide and the output
// register. Every operation travels the same pipeline, so results never overtake each
// other. Add, subtract, scale, dot and cross are finished after the front end and ride
// along unchanged; normalize uses the square root and the three divide lanes. A zero
// vector under normalize gives a zero result with zero_length set. Undefined operation
// codes return an all-zero item. While a result waits in the output register and
// out_stall is high, the whole pipeline holds and in_stall is raised, so nothing is lost
// or repeated; once the output is taken, an item is accepted again in the same cycle.

module vec3_arithmetic_unit (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire v3a_pkg::v3a_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output v3a_pkg::v3a_out_t     out_data
);

  logic              out_valid_r;

  // The pipeline advances whenever the output register is empty or being taken.
  logic adv;
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  logic              f_valid;
  logic [63:0]       f_ssq;
  v3a_pkg::v3a_tag_t f_tag;

  logic              s_valid;
  logic [31:0]       s_root;
  v3a_pkg::v3a_tag_t s_tag;

  logic              d_valid;
  logic [2:0][16:0]  d_q;
  v3a_pkg::v3a_tag_t d_tag;

  v3a_pkg::v3a_out_t out_data_r;
  v3a_pkg::v3a_out_t out_data_nxt;

  v3a_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .out_valid  (f_valid),
    .out_sum_sq (f_ssq),
    .out_tag    (f_tag)
  );

  v3a_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (f_valid),
    .in_s      (f_ssq),
    .in_tag    (f_tag),
    .out_valid (s_valid),
    .out_root  (s_root),
    .out_tag   (s_tag)
  );

  v3a_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (s_valid),
    .in_root   (s_root),
    .in_tag    (s_tag),
    .out_valid (d_valid),
    .out_q     (d_q),
    .out_tag   (d_tag)
  );

  // Normalize results take the quotient with the sign of the input component; the
  // quotient never exceeds 1.0, so no saturation is needed here.
  logic [2:0][31:0] nrm;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      nrm[l] = d_tag.neg[l] ? 32'(-{15'd0, d_q[l]}) : {15'd0, d_q[l]};
    end
    out_data_nxt             = '0;
    out_data_nxt.res_scalar  = d_tag.rs;
    out_data_nxt.overflow    = d_tag.ovf;
    out_data_nxt.zero_length = d_tag.zl;
    if (d_tag.op == v3a_pkg::OP_NORM) begin
      if (!d_tag.zl) begin
        out_data_nxt.res_x = nrm[0];
        out_data_nxt.res_y = nrm[1];
        out_data_nxt.res_z = nrm[2];
      end
    end else begin
      out_data_nxt.res_x = d_tag.rx;
      out_data_nxt.res_y = d_tag.ry;
      out_data_nxt.res_z = d_tag.rz;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[dv/tb_vec3_arithmetic_unit.sv]
// Self-checking testbench for vec3_arithmetic_unit: directed and random vector items,
// random idling on both sides, results compared against a built-in Q16.16 predictor.
// Depends on v3a_pkg and the RTL in src.
`timescale 1ns / 100ps

// Holds the expected result items in order and compares each arriving result.
class vec3_scoreboard;
  v3a_pkg::v3a_out_t pending[$];
  int                errors = 0;

  // Saturate a wide signed value to Q16.16 and note overflow.
  static function logic [31:0] clamp_q(input logic signed [95:0] v, inout logic ovf);
    if (v > 96'sd2147483647) begin
      ovf = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -96'sd2147483648) begin
      ovf = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // Integer square root, floor, of an unsigned value.
  static function logic [63:0] root_floor(input logic [65:0] s);
    logic [65:0] r;
    logic [65:0] bitv;
    r = '0;
    bitv = 66'd1 << 64;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (s >= r + bitv) begin
        s = s - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r[63:0];
  endfunction

  // Work out the result of one input item.
  static function v3a_pkg::v3a_out_t compute_vec3(input v3a_pkg::v3a_in_t d);
    v3a_pkg::v3a_out_t r;
    logic signed [95:0] ax, ay, az, bx, by, bz, f, n;
    logic [65:0] sq;
    logic ovf;
    ax = 96'(d.a_x); ay = 96'(d.a_y); az = 96'(d.a_z);
    bx = 96'(d.b_x); by = 96'(d.b_y); bz = 96'(d.b_z); f = 96'(d.scale_factor);
    r = '0;
    ovf = 1'b0;
    case (d.operation)
      v3a_pkg::OP_ADD: begin
        r.res_x = clamp_q(ax + bx, ovf);
        r.res_y = clamp_q(ay + by, ovf);
        r.res_z = clamp_q(az + bz, ovf);
      end
      v3a_pkg::OP_SUB: begin
        r.res_x = clamp_q(ax - bx, ovf);
        r.res_y = clamp_q(ay - by, ovf);
        r.res_z = clamp_q(az - bz, ovf);
      end
      // Arithmetic shift right of the exact product rounds toward minus infinity.
      v3a_pkg::OP_SCALE: begin
        r.res_x = clamp_q((f * ax) >>> 16, ovf);
        r.res_y = clamp_q((f * ay) >>> 16, ovf);
        r.res_z = clamp_q((f * az) >>> 16, ovf);
      end
      v3a_pkg::OP_DOT: r.res_scalar = clamp_q((ax * bx + ay * by + az * bz) >>> 16, ovf);
      v3a_pkg::OP_CROSS: begin
        r.res_x = clamp_q((ay * bz - az * by) >>> 16, ovf);
        r.res_y = clamp_q((az * bx - ax * bz) >>> 16, ovf);
        r.res_z = clamp_q((ax * by - ay * bx) >>> 16, ovf);
      end
      v3a_pkg::OP_NORM: begin
        sq = 66'(ax * ax + ay * ay + az * az);
        if (sq == 0) begin
          r.zero_length = 1'b1;
        end else begin
          // Signed division in SystemVerilog truncates toward zero.
          n = $signed({32'd0, root_floor(sq)});
          r.res_x = 32'((ax * 65536) / n);
          r.res_y = 32'((ay * 65536) / n);
          r.res_z = 32'((az * 65536) / n);
        end
      end
      default: ;
    endcase
    r.overflow = ovf;
    return r;
  endfunction

  function void note_input(input v3a_pkg::v3a_in_t d);
    pending.push_back(compute_vec3(d));
  endfunction

  function void check_result(input v3a_pkg::v3a_out_t got);
    v3a_pkg::v3a_out_t want;
    if (pending.size() == 0) begin
      $error("result with nothing expected: %h", got);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got.res_x !== want.res_x) begin
      $error("res_x expected %h actual %h", want.res_x, got.res_x); errors++;
    end
    if (got.res_y !== want.res_y) begin
      $error("res_y expected %h actual %h", want.res_y, got.res_y); errors++;
    end
    if (got.res_z !== want.res_z) begin
      $error("res_z expected %h actual %h", want.res_z, got.res_z); errors++;
    end
    if (got.res_scalar !== want.res_scalar) begin
      $error("res_scalar expected %h actual %h", want.res_scalar, got.res_scalar); errors++;
    end
    if (got.overflow !== want.overflow) begin
      $error("overflow expected %b actual %b", want.overflow, got.overflow); errors++;
    end
    if (got.zero_length !== want.zero_length) begin
      $error("zero_length expected %b actual %b", want.zero_length, got.zero_length);
      errors++;
    end
  endfunction
endclass

module tb_vec3_arithmetic_unit;
  // Pipeline depth of the block; the settling wait after the final drain is sized around it.
  localparam int PIPE_DEPTH = 52;
  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 800;

  // Operation codes with no defined meaning; the block answers them with an all-zero item.
  localparam logic [2:0] OP_RSVD_6 = 3'd6;
  localparam logic [2:0] OP_RSVD_7 = 3'd7;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  v3a_pkg::v3a_in_t  in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  v3a_pkg::v3a_out_t out_data;

  vec3_scoreboard results = new();
  bit  long_hold_req = 0;
  int  idle_cycles = 0;

  vec3_arithmetic_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Scoreboard hooks and the watchdog all sample on the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) results.note_input(in_data);
      if (out_valid && !out_stall) results.check_result(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Offer one item and hold it until the block takes it. Gap cycles come first, so the
  // valid line stays high across back-to-back items without being lowered in between.
  task automatic send_item(input v3a_pkg::v3a_in_t d);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_op(input logic [2:0] op, input logic [31:0] ax, ay, az,
                         input logic [31:0] bx, by, bz, f);
    v3a_pkg::v3a_in_t d;
    d.operation = op;
    d.a_x = ax; d.a_y = ay; d.a_z = az;
    d.b_x = bx; d.b_y = by; d.b_z = bz;
    d.scale_factor = f;
    send_item(d);
  endtask

  // Random component: mostly moderate magnitudes so products stay in range, with
  // full-width values and extremes mixed in to reach saturation.
  function automatic logic [31:0] rand_q();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 65535)) - 32768);
      3: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom())};
      default: return {{14{$urandom_range(0, 1) == 1}}, 18'($urandom())};
    endcase
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (results.pending.size() != 0) @(negedge clk);
  endtask

  // Receiver: random stall per cycle run, plus one long hold on request.
  initial begin
    int hold;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (200) @(negedge clk);
        long_hold_req = 0;
      end
      hold = $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0) hold = 0;
      out_stall <= (hold != 0);
      if (hold > 1) repeat (hold - 1) @(negedge clk);
    end
  end

  initial begin
    v3a_pkg::v3a_in_t d;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed items: field extremes, every operation, zero vector, overflow, undefined codes.
    send_op(v3a_pkg::OP_ADD,   32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000,
            32'h0000_0001, 32'hFFFF_FFFF, 32'h0002_0000, 32'h0);
    send_op(v3a_pkg::OP_SUB,   32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
            32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    send_op(v3a_pkg::OP_SCALE, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF,
            32'h0, 32'h0, 32'h0, 32'h0002_0000);
    send_op(v3a_pkg::OP_SCALE, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
            32'h0, 32'h0, 32'h0, 32'h8000_0000);
    send_op(v3a_pkg::OP_SCALE, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_8000,
            32'h0, 32'h0, 32'h0, 32'h0000_0001);
    send_op(v3a_pkg::OP_DOT,   32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
            32'h0004_0000, 32'h0005_0000, 32'h0006_0000, 32'h0);
    send_op(v3a_pkg::OP_DOT,   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0);
    send_op(v3a_pkg::OP_DOT,   32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_op(v3a_pkg::OP_DOT,   32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0000_0001, 32'h0, 32'h0,
            32'h0);
    send_op(v3a_pkg::OP_CROSS, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0,
            32'h0);
    send_op(v3a_pkg::OP_CROSS, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
            32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
    send_op(v3a_pkg::OP_NORM,  32'h0, 32'h0, 32'h0, 32'h1234_5678, 32'h0, 32'h0, 32'h0);
    send_op(v3a_pkg::OP_NORM,  32'h0003_0000, 32'h0004_0000, 32'h0, 32'h0, 32'h0, 32'h0,
            32'h0);
    send_op(v3a_pkg::OP_NORM,  32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h0, 32'h0, 32'h0, 32'h0);
    send_op(v3a_pkg::OP_NORM,  32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h0, 32'h0, 32'h0,
            32'h0);
    send_op(v3a_pkg::OP_NORM,  32'h0000_0001, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_op(v3a_pkg::OP_NORM,  32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_op(OP_RSVD_6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(OP_RSVD_7, 32'h7FFF_FFFF, 32'h1, 32'h2, 32'h3, 32'h4, 32'h5, 32'h6);

    // Sender pause: let every expected result come home before going on.
    wait_drained();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // Partway through, the receiver holds off long enough to back up the pipeline.
      if (i == 200) long_hold_req = 1;
      if (i == 500) wait_drained();
      if ($urandom_range(0, 19) == 0) begin
        d.operation = $urandom_range(0, 1) ? OP_RSVD_7 : OP_RSVD_6;
      end else begin
        d.operation = 3'($urandom_range(v3a_pkg::OP_ADD, v3a_pkg::OP_NORM));
      end
      d.a_x = rand_q(); d.a_y = rand_q(); d.a_z = rand_q();
      d.b_x = rand_q(); d.b_y = rand_q(); d.b_z = rand_q();
      d.scale_factor = rand_q();
      if (d.operation == v3a_pkg::OP_NORM && $urandom_range(0, 15) == 0) begin
        d.a_x = '0; d.a_y = '0; d.a_z = '0;
      end
      send_item(d);
    end

    wait_drained();
    repeat (2 * PIPE_DEPTH) @(negedge clk);
    if (results.errors == 0 && results.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

[sim.f]
src/v3a_pkg.sv
src/v3a_front.sv
src/v3a_sqrt.sv
src/v3a_div.sv
src/vec3_arithmetic_unit.sv
dv/tb_vec3_arithmetic_unit.sv
